// ===== rtl/core/itp_pkg.sv =====
// ----------------------------------------------------------------------------
// itp_pkg
// Shared types, character codes and helper functions for the infix to
// postfix converter.
// ----------------------------------------------------------------------------
`default_nettype none

package itp_pkg;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_MUL   = 8'h2A;
    localparam logic [7:0] CH_DIV   = 8'h2F;
    localparam logic [7:0] CH_POW   = 8'h5E;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_NUL   = 8'h00;

    typedef logic signed [2:0] prec_t;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_WORK  = 3'b010,
        S_FLUSH = 3'b100
    } state_t;

    typedef enum logic [2:0] {
        ACT_POP,
        ACT_EMIT,
        ACT_PUSH,
        ACT_DROP,
        ACT_DONE
    } action_t;

    function automatic prec_t prec_of(input logic [7:0] c);
        prec_t p;
        unique case (c)
            CH_PLUS, CH_MINUS: p = 3'sd1;
            CH_MUL, CH_DIV:    p = 3'sd2;
            CH_POW:            p = 3'sd3;
            default:           p = -3'sd1;
        endcase
        return p;
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/itp_ram.sv =====
// ----------------------------------------------------------------------------
// itp_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module itp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/infix_to_postfix_converter.sv =====
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// Shunting-yard converter: infix characters in, postfix characters out.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries one word per character, with
// end_of_expr marking the end of an expression. Output channel
// (out_valid/out_ready) carries the postfix characters; run_last marks the
// final word caused by an input word, overflow marks a dropped push, and a
// zero character terminates each expression.
// An input word is taken in S_IDLE and handled in S_WORK, which pops one
// operator off the stack per step, then S_FLUSH passes on the last word when
// it produced any. The operator stack lives in a RAM with a registered read,
// and the entry below the top is read while the top is emitted, so pops
// stream at one per cycle while the output does not stall.
// in_ready is high only while no word is in progress. The last produced
// word is held back in a pending register so that run_last can be set on it.
// Reset empties the stack and drops any pending output; the stack RAM
// itself is not cleared, as only written entries are ever used.
// A stall on the output holds the converter in place; nothing is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module infix_to_postfix_converter
    import itp_pkg::*;
#(
    parameter int STACK_DEPTH = 32
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] char_in,
    input  wire logic       end_of_expr,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic      [7:0] char_out,
    output logic            run_last,
    output logic            overflow
);

    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               fresh_reg, fresh_next;
    logic               pend_valid_reg, pend_valid_next;
    logic               out_valid_reg, out_valid_next;
    logic [7:0]         char_reg, char_next;
    logic               end_reg, end_next;
    logic [7:0]         top_reg, top_next;
    logic [7:0]         pend_char_reg, pend_char_next;
    logic               pend_ovf_reg, pend_ovf_next;
    logic [7:0]         out_char_reg, out_char_next;
    logic               out_last_reg, out_last_next;
    logic               out_ovf_reg, out_ovf_next;

    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ADDR_W-1:0]  rd_addr;
    logic [7:0]         rd_data;

    logic [7:0]         top_val;
    logic               has_items;
    logic               full;
    logic               out_free;
    logic               emit_ok;
    action_t            act;
    logic [7:0]         emit_char;
    logic               emit_ovf;

    itp_ram #(
        .WIDTH (8),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (char_reg),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Right after a pop the new top is still in the RAM read register.
    assign top_val   = fresh_reg ? rd_data : top_reg;
    assign has_items = (cnt_reg != '0);
    assign full      = (cnt_reg == CNT_W'(STACK_DEPTH));
    assign out_free  = !out_valid_reg || out_ready;
    assign emit_ok   = !pend_valid_reg || out_free;
    assign wr_addr   = cnt_reg[ADDR_W-1:0];
    assign rd_addr   = ADDR_W'(cnt_reg - CNT_W'(2));

    always_comb
    begin
        act       = ACT_DONE;
        emit_char = char_reg;
        emit_ovf  = 1'b0;
        if (end_reg)
        begin
            emit_char = CH_NUL;
            act       = has_items ? ACT_POP : ACT_EMIT;
        end
        else if (is_letter(char_reg))
        begin
            act = ACT_EMIT;
        end
        else if (char_reg == CH_LPAR)
        begin
            act      = full ? ACT_EMIT : ACT_PUSH;
            emit_ovf = 1'b1;
        end
        else if (char_reg == CH_RPAR)
        begin
            if (has_items && (top_val != CH_LPAR))
            begin
                act = ACT_POP;
            end
            else if (has_items)
            begin
                act = ACT_DROP;
            end
            else
            begin
                act = ACT_DONE;
            end
        end
        else
        begin
            emit_ovf = 1'b1;
            if (has_items && (prec_of(char_reg) <= prec_of(top_val)))
            begin
                act = ACT_POP;
            end
            else
            begin
                act = full ? ACT_EMIT : ACT_PUSH;
            end
        end
        if (act == ACT_POP)
        begin
            emit_char = top_val;
            emit_ovf  = 1'b0;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        fresh_next      = 1'b0;
        pend_valid_next = pend_valid_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        char_next       = char_reg;
        end_next        = end_reg;
        top_next        = top_val;
        pend_char_next  = pend_char_reg;
        pend_ovf_next   = pend_ovf_reg;
        out_char_next   = out_char_reg;
        out_last_next   = out_last_reg;
        out_ovf_next    = out_ovf_reg;
        wr_en           = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    char_next  = char_in;
                    end_next   = end_of_expr;
                    state_next = S_WORK;
                end
            end
            S_WORK:
            begin
                if ((act == ACT_POP) || (act == ACT_EMIT))
                begin
                    if (emit_ok)
                    begin
                        // The held-back word is now known not to be the last.
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_char_next  = pend_char_reg;
                            out_last_next  = 1'b0;
                            out_ovf_next   = pend_ovf_reg;
                        end
                        pend_valid_next = 1'b1;
                        pend_char_next  = emit_char;
                        pend_ovf_next   = emit_ovf;
                        if (act == ACT_POP)
                        begin
                            cnt_next   = cnt_reg - CNT_W'(1);
                            fresh_next = 1'b1;
                        end
                        else
                        begin
                            state_next = S_FLUSH;
                        end
                    end
                end
                else
                begin
                    if (act == ACT_PUSH)
                    begin
                        wr_en    = 1'b1;
                        top_next = char_reg;
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                    else if (act == ACT_DROP)
                    begin
                        cnt_next   = cnt_reg - CNT_W'(1);
                        fresh_next = 1'b1;
                    end
                    state_next = pend_valid_reg ? S_FLUSH : S_IDLE;
                end
            end
            S_FLUSH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_char_next   = pend_char_reg;
                    out_last_next   = 1'b1;
                    out_ovf_next    = pend_ovf_reg;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            fresh_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            fresh_reg      <= fresh_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg      <= char_next;
        end_reg       <= end_next;
        top_reg       <= top_next;
        pend_char_reg <= pend_char_next;
        pend_ovf_reg  <= pend_ovf_next;
        out_char_reg  <= out_char_next;
        out_last_reg  <= out_last_next;
        out_ovf_reg   <= out_ovf_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign char_out  = out_char_reg;
    assign run_last  = out_last_reg;
    assign overflow  = out_ovf_reg;

endmodule

`default_nettype wire
